// ----- rtl/smam_pkg.sv -----
// Shared types, constants and the microprogram of the sparse matrix adder.
// Used by smam_useq and sparse_matrix_add_merge_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smam_pkg;

	localparam int LIST_DEPTH_DEF = 32;
	localparam int INDEX_BITS_DEF = 8;

	localparam int CMD_W = 2;
	localparam int ROW_W = 8;
	localparam int VAL_W = 32;
	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_MERGE  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A = 2'd0,
		REG_COLS_A = 2'd1,
		REG_ROWS_B = 2'd2,
		REG_COLS_B = 2'd3
	} reg_idx_t;

	typedef logic [1:0] step_t;

	localparam step_t ST_IDLE  = 2'd0;
	localparam step_t ST_CHECK = 2'd1;
	localparam step_t ST_MERGE = 2'd2;

	typedef enum logic [1:0] {
		COND_MERGE_CMD = 2'd0,
		COND_SPECIAL   = 2'd1,
		COND_DONE      = 2'd2
	} cond_t;

	typedef struct packed {
		logic  idle;
		logic  chk;
		logic  mrg;
		cond_t cond;
		step_t target;
		step_t next;
	} uword_t;

	typedef struct packed {
		logic merge_cmd;
		logic special;
		logic done;
	} seq_flags_t;

	typedef struct packed {
		uword_t uw;
		logic   taken;
	} seq_ctrl_t;

	function automatic uword_t ucode_rom(input step_t pc);
		uword_t w;
		case (pc)
			ST_IDLE:  w = '{idle: 1'b1, chk: 1'b0, mrg: 1'b0, cond: COND_MERGE_CMD,
				target: ST_CHECK, next: ST_IDLE};
			ST_CHECK: w = '{idle: 1'b0, chk: 1'b1, mrg: 1'b0, cond: COND_SPECIAL,
				target: ST_IDLE, next: ST_MERGE};
			ST_MERGE: w = '{idle: 1'b0, chk: 1'b0, mrg: 1'b1, cond: COND_DONE,
				target: ST_IDLE, next: ST_MERGE};
			default:  w = '{idle: 1'b0, chk: 1'b0, mrg: 1'b0, cond: COND_DONE,
				target: ST_IDLE, next: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/smam_useq.sv -----
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on smam_pkg for the control word layout and the program.
`timescale 1ns / 1ps
`default_nettype none

module smam_useq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  smam_pkg::seq_flags_t flags,
	output smam_pkg::seq_ctrl_t  ctrl
);
	import smam_pkg::*;

	step_t  pc_q;
	uword_t uw;
	logic   taken;

	always_comb begin
		uw = ucode_rom(pc_q);
		case (uw.cond)
			COND_MERGE_CMD: taken = flags.merge_cmd;
			COND_SPECIAL:   taken = flags.special;
			COND_DONE:      taken = flags.done;
			default:        taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= taken ? uw.target : uw.next;
		end
	end

	assign ctrl = '{uw: uw, taken: taken};

endmodule

`default_nettype wire

// ----- rtl/sparse_matrix_add_merge_top.sv -----
// Top level of the sparse matrix adder: list memories, pointers and merge datapath.
// Depends on smam_pkg and on smam_useq, which sequences the merge.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Signals                                   Handshake
// command     command, row, col, value                  start high while busy low
// result      out_row, out_col, out_value, last,        valid high for one cycle
//             empty_res, dim_error
// config      cfg_we, cfg_index, cfg_data               cfg_we high, no wait
//
// A merge runs a check step and then yields one merged word per cycle; a
// dimension error or two empty lists end at the check step. Each result
// leaves the output register in the cycle after its step.
// The merge rate is set by the single read port of each list memory.
// Reset clears both counts and sets all dimensions to 16; the list memories are
// not cleared. The receiver cannot stall, so results never wait.

module sparse_matrix_add_merge_top #(
	parameter int LIST_DEPTH = smam_pkg::LIST_DEPTH_DEF,
	parameter int INDEX_BITS = smam_pkg::INDEX_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [smam_pkg::CMD_W-1:0]           command,
	input  wire  [smam_pkg::ROW_W-1:0]           row,
	input  wire  [smam_pkg::ROW_W-1:0]           col,
	input  wire  signed [smam_pkg::VAL_W-1:0]    value,
	input  wire                                  cfg_we,
	input  wire  [smam_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [smam_pkg::CFG_W-1:0]           cfg_data,
	output logic                                 valid,
	output logic [smam_pkg::ROW_W-1:0]           out_row,
	output logic [smam_pkg::ROW_W-1:0]           out_col,
	output logic signed [smam_pkg::VAL_W-1:0]    out_value,
	output logic                                 last,
	output logic                                 empty_res,
	output logic                                 dim_error
);
	import smam_pkg::*;

	localparam int IW = (INDEX_BITS < ROW_W) ? INDEX_BITS : ROW_W;
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int EW = 2 * IW + VAL_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	logic [EW-1:0] mem_a [LIST_DEPTH];
	logic [EW-1:0] mem_b [LIST_DEPTH];
	logic [EW-1:0] rd_a_q, rd_b_q;

	logic [CW-1:0] count_a_q, count_b_q, i_q, j_q, i_nx, j_nx;
	logic [CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

	seq_flags_t flags;
	seq_ctrl_t  ctrl;

	logic          accept, ld_a, ld_b, clr_cnt;
	logic          mismatch, both_empty;
	logic          va, vb, a_lt, b_sel, adv_a, adv_b, emit;
	logic [IW-1:0] a_row, a_col, b_row, b_col, sel_row, sel_col;
	logic [VAL_W-1:0] a_val, b_val, sel_val;
	logic [EW-1:0] wr_word;

	smam_useq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign busy    = ~ctrl.uw.idle;
	assign accept  = start & ~busy;
	assign ld_a    = accept && (command == CMD_LOAD_A) && (count_a_q < DEPTH_C);
	assign ld_b    = accept && (command == CMD_LOAD_B) && (count_b_q < DEPTH_C);
	assign wr_word = {row[IW-1:0], col[IW-1:0], value};

	assign mismatch   = (rows_a_q != rows_b_q) || (cols_a_q != cols_b_q);
	assign both_empty = (count_a_q == '0) && (count_b_q == '0);

	assign {a_row, a_col, a_val} = rd_a_q;
	assign {b_row, b_col, b_val} = rd_b_q;

	always_comb begin
		va    = i_q < count_a_q;
		vb    = j_q < count_b_q;
		a_lt  = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));
		b_sel = (b_row < a_row) || (b_col < a_col);
		adv_a = 1'b0;
		adv_b = 1'b0;
		sel_row = a_row;
		sel_col = a_col;
		sel_val = a_val;
		if (va && vb) begin
			if (a_lt) begin
				adv_a = 1'b1;
			end else if (b_sel) begin
				adv_b   = 1'b1;
				sel_row = b_row;
				sel_col = b_col;
				sel_val = b_val;
			end else begin
				adv_a   = 1'b1;
				adv_b   = 1'b1;
				sel_val = a_val + b_val;
			end
		end else if (va) begin
			adv_a = 1'b1;
		end else begin
			adv_b   = 1'b1;
			sel_row = b_row;
			sel_col = b_col;
			sel_val = b_val;
		end
		if (ctrl.uw.chk) begin
			i_nx = '0;
			j_nx = '0;
		end else begin
			i_nx = i_q + CW'(adv_a);
			j_nx = j_q + CW'(adv_b);
		end
	end

	assign flags = '{
		merge_cmd: accept && (command == CMD_MERGE),
		special:   mismatch || both_empty,
		done:      (i_nx >= count_a_q) && (j_nx >= count_b_q)
	};

	assign clr_cnt = ctrl.taken && (ctrl.uw.chk || ctrl.uw.mrg);
	assign emit    = ctrl.uw.mrg || (ctrl.uw.chk && flags.special);

	always_ff @(posedge clk) begin
		if (ld_a) begin
			mem_a[count_a_q[AW-1:0]] <= wr_word;
		end
		if (ld_b) begin
			mem_b[count_b_q[AW-1:0]] <= wr_word;
		end
		rd_a_q <= mem_a[i_nx[AW-1:0]];
		rd_b_q <= mem_b[j_nx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			rows_a_q  <= DIM_RESET;
			cols_a_q  <= DIM_RESET;
			rows_b_q  <= DIM_RESET;
			cols_b_q  <= DIM_RESET;
			valid     <= 1'b0;
		end else begin
			if (clr_cnt) begin
				count_a_q <= '0;
				count_b_q <= '0;
			end else begin
				if (ld_a) begin
					count_a_q <= count_a_q + CW'(1);
				end
				if (ld_b) begin
					count_b_q <= count_b_q + CW'(1);
				end
			end
			i_q <= i_nx;
			j_q <= j_nx;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_A: rows_a_q <= cfg_data;
					REG_COLS_A: cols_a_q <= cfg_data;
					REG_ROWS_B: rows_b_q <= cfg_data;
					REG_COLS_B: cols_b_q <= cfg_data;
					default: ;
				endcase
			end
			valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ctrl.uw.chk) begin
				out_row   <= '0;
				out_col   <= '0;
				out_value <= '0;
				last      <= 1'b1;
				empty_res <= ~mismatch;
				dim_error <= mismatch;
			end else begin
				out_row   <= ROW_W'(sel_row);
				out_col   <= ROW_W'(sel_col);
				out_value <= sel_val;
				last      <= flags.done;
				empty_res <= 1'b0;
				dim_error <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sim/smam_merge_check.sv -----
// Watches the command, config and result channels of the sparse matrix adder.
// Keeps its own copy of both coordinate lists, predicts each merge and compares.
// Depends on smam_pkg for widths and codes.
`timescale 1ns / 1ps

module smam_merge_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [smam_pkg::CMD_W-1:0]         command,
	input  logic [smam_pkg::ROW_W-1:0]         row,
	input  logic [smam_pkg::ROW_W-1:0]         col,
	input  logic [smam_pkg::VAL_W-1:0]         value,
	input  logic                               cfg_we,
	input  logic [smam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smam_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               valid,
	input  logic [smam_pkg::ROW_W-1:0]         out_row,
	input  logic [smam_pkg::ROW_W-1:0]         out_col,
	input  logic [smam_pkg::VAL_W-1:0]         out_value,
	input  logic                               last,
	input  logic                               empty_res,
	input  logic                               dim_error,
	output int                                 mismatches,
	output int                                 outstanding,
	output int                                 words_seen
);
	import smam_pkg::*;

	typedef struct packed {
		logic [ROW_W-1:0] r;
		logic [ROW_W-1:0] c;
		logic [VAL_W-1:0] v;
	} coord_t;

	typedef struct packed {
		logic [ROW_W-1:0] r;
		logic [ROW_W-1:0] c;
		logic [VAL_W-1:0] v;
		logic             fin;
		logic             none;
		logic             err;
	} merged_word_t;

	coord_t       list_a [LIST_DEPTH_DEF];
	coord_t       list_b [LIST_DEPTH_DEF];
	int           count_a;
	int           count_b;
	logic [CFG_W-1:0] rows_a, cols_a, rows_b, cols_b;
	merged_word_t sums_due [$];

	function automatic merged_word_t plain_word(coord_t e, logic [VAL_W-1:0] v);
		merged_word_t w;
		w = '0;
		w.r = e.r;
		w.c = e.c;
		w.v = v;
		return w;
	endfunction

	task automatic predict_merge();
		int i;
		int j;
		merged_word_t w;
		i = 0;
		j = 0;
		w = '0;
		if (rows_a != rows_b || cols_a != cols_b) begin
			w.fin = 1'b1;
			w.err = 1'b1;
			sums_due.push_back(w);
		end else if (count_a == 0 && count_b == 0) begin
			w.fin = 1'b1;
			w.none = 1'b1;
			sums_due.push_back(w);
		end else begin
			while (i < count_a && j < count_b) begin
				if (list_a[i].r < list_b[j].r ||
						(list_a[i].r == list_b[j].r && list_a[i].c < list_b[j].c)) begin
					sums_due.push_back(plain_word(list_a[i], list_a[i].v));
					i++;
				end else if (list_b[j].r < list_a[i].r || list_b[j].c < list_a[i].c) begin
					sums_due.push_back(plain_word(list_b[j], list_b[j].v));
					j++;
				end else begin
					sums_due.push_back(plain_word(list_a[i], list_a[i].v + list_b[j].v));
					i++;
					j++;
				end
			end
			for (; i < count_a; i++)
				sums_due.push_back(plain_word(list_a[i], list_a[i].v));
			for (; j < count_b; j++)
				sums_due.push_back(plain_word(list_b[j], list_b[j].v));
			w = sums_due.pop_back();
			w.fin = 1'b1;
			sums_due.push_back(w);
		end
		count_a = 0;
		count_b = 0;
	endtask

	task automatic report(input string what, input merged_word_t e, input merged_word_t g);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t ns %s: expected row %0d col %0d value %0d last %0b empty %0b err %0b;",
				$time, what, e.r, e.c, $signed(e.v), e.fin, e.none, e.err);
			$display("    got row %0d col %0d value %0d last %0b empty %0b err %0b",
				g.r, g.c, $signed(g.v), g.fin, g.none, g.err);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		merged_word_t got;
		merged_word_t want;
		coord_t       loaded;
		if (!arst_n) begin
			count_a = 0;
			count_b = 0;
			rows_a = DIM_RESET;
			cols_a = DIM_RESET;
			rows_b = DIM_RESET;
			cols_b = DIM_RESET;
			sums_due.delete();
			mismatches = 0;
			words_seen = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ROWS_A: rows_a = cfg_data;
					REG_COLS_A: cols_a = cfg_data;
					REG_ROWS_B: rows_b = cfg_data;
					REG_COLS_B: cols_b = cfg_data;
					default: ;
				endcase
			end
			if (valid) begin
				words_seen++;
				got = '{r: out_row, c: out_col, v: out_value, fin: last,
					none: empty_res, err: dim_error};
				if (sums_due.size() == 0) begin
					report("word with nothing expected", '0, got);
				end else begin
					want = sums_due.pop_front();
					if (got.r !== want.r || got.c !== want.c || got.v !== want.v ||
							got.fin !== want.fin || got.none !== want.none ||
							got.err !== want.err)
						report("wrong merged word", want, got);
				end
			end
			if (start && !busy) begin
				loaded = '{r: row, c: col, v: value};
				case (command)
					CMD_LOAD_A: begin
						if (count_a < LIST_DEPTH_DEF) begin
							list_a[count_a] = loaded;
							count_a++;
						end
					end
					CMD_LOAD_B: begin
						if (count_b < LIST_DEPTH_DEF) begin
							list_b[count_b] = loaded;
							count_b++;
						end
					end
					CMD_MERGE: predict_merge();
					default: ;
				endcase
			end
		end
		outstanding = sums_due.size();
	end

endmodule

// ----- sim/sparse_matrix_add_merge_top_test.sv -----
// Stimulus and verdict for sparse_matrix_add_merge_top: directed corner cases, then
// mostly sorted coordinate lists of random data under several dimension settings.
// Depends on smam_pkg, the block itself and smam_merge_check.
`timescale 1ns / 1ps

module sparse_matrix_add_merge_top_test;
	import smam_pkg::*;

	localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
	localparam int FULL_DEPTH = LIST_DEPTH_DEF;

	typedef struct packed {
		logic [ROW_W-1:0] r;
		logic [ROW_W-1:0] c;
		logic [VAL_W-1:0] v;
	} coord_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [CMD_W-1:0]        command = CMD_LOAD_A;
	logic [ROW_W-1:0]        row = '0;
	logic [ROW_W-1:0]        col = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    cfg_we = 1'b0;
	reg_idx_t                cfg_index = REG_ROWS_A;
	logic [CFG_W-1:0]        cfg_data = DIM_RESET;
	logic                    busy;
	logic                    valid;
	logic [ROW_W-1:0]        out_row;
	logic [ROW_W-1:0]        out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    last;
	logic                    empty_res;
	logic                    dim_error;
	int                      mismatches;
	int                      outstanding;
	int                      words_seen;

	int idle_pct = 0;
	int cur_rows = 16;
	int cur_cols = 16;
	int words_sent = 0;
	int merges_sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sparse_matrix_add_merge_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.row       (row),
		.col       (col),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid     (valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.last      (last),
		.empty_res (empty_res),
		.dim_error (dim_error)
	);

	smam_merge_check merge_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.row         (row),
		.col         (col),
		.value       (value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.valid       (valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.last        (last),
		.empty_res   (empty_res),
		.dim_error   (dim_error),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.words_seen  (words_seen)
	);

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_word(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] c, input logic [VAL_W-1:0] v);
		int gap;
		gap = 0;
		start <= 1'b1;
		command <= cmd;
		row <= r;
		col <= c;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
		if (cmd == CMD_MERGE)
			merges_sent++;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_dims(input int ra, input int ca, input int rb, input int cb);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data <= CFG_W'(ra);
		@(posedge clk);
		cfg_index <= REG_COLS_A;
		cfg_data <= CFG_W'(ca);
		@(posedge clk);
		cfg_index <= REG_ROWS_B;
		cfg_data <= CFG_W'(rb);
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data <= CFG_W'(cb);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_rows = ra;
		cur_cols = ca;
	endtask

	task automatic run_sequence(input int na, input int nb, input bit scramble,
			output int counted);
		coord_t qa [$];
		coord_t qb [$];
		coord_t e;
		coord_t tmp;
		logic [VAL_W-1:0] shared;
		int total;
		int span;
		int p;
		int pick;
		int k;
		total = cur_rows * cur_cols;
		span = 1 + (2 * total) / (na + nb + 1);
		p = $urandom_range(0, span - 1);
		while ((qa.size() < na || qb.size() < nb) && p < total) begin
			e.r = ROW_W'(p / cur_cols);
			e.c = ROW_W'(p % cur_cols);
			e.v = pick_value();
			pick = $urandom_range(99);
			if (qa.size() < na && (pick < 35 || qb.size() >= nb)) begin
				qa.push_back(e);
			end else if (qb.size() < nb && (pick < 70 || qa.size() >= na)) begin
				qb.push_back(e);
			end else begin
				shared = e.v;
				qa.push_back(e);
				e.v = ($urandom_range(3) == 0) ? -shared : pick_value();
				qb.push_back(e);
			end
			p += $urandom_range(1, span);
		end
		if (scramble && qa.size() >= 2) begin
			k = $urandom_range(1, qa.size() - 1);
			tmp = qa[0];
			qa[0] = qa[k];
			qa[k] = tmp;
		end
		counted = 1 + (qa.size() > FULL_DEPTH ? FULL_DEPTH : qa.size()) +
			(qb.size() > FULL_DEPTH ? FULL_DEPTH : qb.size());
		while (qa.size() + qb.size() > 0) begin
			if ($urandom_range(15) == 0)
				put_word(CMD_IGNORED, ROW_W'($urandom), ROW_W'($urandom), $urandom);
			if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(1) == 0)) begin
				e = qa.pop_front();
				put_word(CMD_LOAD_A, e.r, e.c, e.v);
			end else begin
				e = qb.pop_front();
				put_word(CMD_LOAD_B, e.r, e.c, e.v);
			end
		end
		put_word(CMD_MERGE, ROW_W'($urandom), ROW_W'($urandom), $urandom);
	endtask

	task automatic run_phase(input int ra, input int ca, input int rb, input int cb,
			input int pct, input int budget, input bit force_full);
		int done;
		int seq;
		int na;
		int nb;
		int n;
		done = 0;
		seq = 0;
		set_dims(ra, ca, rb, cb);
		idle_pct = pct;
		while (done < budget) begin
			case ($urandom_range(11))
				0: begin
					na = 0;
					nb = 0;
				end
				1: begin
					na = FULL_DEPTH + $urandom_range(1, 3);
					nb = $urandom_range(0, FULL_DEPTH + 2);
				end
				2: begin
					na = 0;
					nb = $urandom_range(1, 6);
				end
				3: begin
					na = $urandom_range(1, 6);
					nb = 0;
				end
				default: begin
					na = $urandom_range(1, 8);
					nb = $urandom_range(1, 8);
				end
			endcase
			if (force_full && seq == 0) begin
				na = FULL_DEPTH + 2;
				nb = FULL_DEPTH;
			end
			run_sequence(na, nb, $urandom_range(9) == 0, n);
			done += n;
			seq++;
		end
		idle_pct = 0;
	endtask

	initial begin
		int ra;
		int ca;
		int rb;
		int cb;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);
		put_word(CMD_LOAD_A, 8'd0, 8'd0, 32'h7fff_ffff);
		put_word(CMD_LOAD_B, 8'd0, 8'd0, 32'd1);
		put_word(CMD_LOAD_A, 8'd3, 8'd4, -32'sd5);
		put_word(CMD_LOAD_B, 8'd3, 8'd2, 32'd9);
		put_word(CMD_LOAD_B, 8'd3, 8'd4, 32'd5);
		put_word(CMD_IGNORED, 8'hff, 8'hff, 32'hffff_ffff);
		put_word(CMD_LOAD_A, 8'd255, 8'd255, 32'h8000_0000);
		put_word(CMD_LOAD_B, 8'd255, 8'd255, 32'h8000_0000);
		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);
		put_word(CMD_LOAD_A, 8'd5, 8'd5, 32'd1);
		put_word(CMD_LOAD_A, 8'd1, 8'd1, 32'd2);
		put_word(CMD_LOAD_B, 8'd2, 8'd2, 32'd3);
		put_word(CMD_LOAD_B, 8'd0, 8'd9, 32'd4);
		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);
		put_word(CMD_LOAD_B, 8'd9, 8'd9, -32'sd1);
		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);
		set_dims(1, 256, 256, 256);
		put_word(CMD_LOAD_A, 8'd0, 8'd0, 32'd1);
		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);
		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);
		set_dims(256, 1, 256, 256);
		put_word(CMD_MERGE, 8'd0, 8'd0, 32'd0);

		run_phase(16, 16, 16, 16, 0, 15, 1'b0);
		run_phase(256, 256, 256, 256, 74, 40, 1'b1);
		run_phase(1, 1, 1, 1, 0, 10, 1'b0);
		ra = $urandom_range(1, 256);
		ca = $urandom_range(1, 256);
		run_phase(ra, ca, ra, ca, 32, 15, 1'b0);
		ra = $urandom_range(1, 256);
		ca = $urandom_range(1, 256);
		rb = ra;
		cb = ca;
		if ($urandom_range(1) == 0)
			rb = (ra % 256) + 1;
		else
			cb = (ca % 256) + 1;
		run_phase(ra, ca, rb, cb, 74, 10, 1'b0);
		ra = $urandom_range(1, 256);
		ca = $urandom_range(1, 256);
		run_phase(ra, ca, ra, ca, 32, 15, 1'b0);

		settle();
		$display("Sent %0d command words including %0d merges over nine dimension settings.",
			words_sent, merges_sent);
		$display("Checked %0d result words; %0d did not agree with the prediction.",
			words_seen, mismatches);
		if (mismatches == 0)
			$display("sparse_matrix_add_merge_top: match");
		else
			$display("sparse_matrix_add_merge_top: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run did not finish in time.");
		$display("sparse_matrix_add_merge_top: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/smam_pkg.sv
rtl/smam_useq.sv
rtl/sparse_matrix_add_merge_top.sv
sim/smam_merge_check.sv
sim/sparse_matrix_add_merge_top_test.sv
